FILE: sv/mfpt_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback position tracker package
// Shared constants, register indexes and pipeline types.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpt_pkg;

  // Encoder geometry
  localparam int unsigned ENC_BITS   = 13;
  localparam int unsigned ENC_COUNTS = 8192;
  localparam int unsigned ENC_HALF   = ENC_COUNTS / 2;
  localparam int unsigned TURN_BITS  = 24;

  // Field widths
  localparam int unsigned DELTA_W = 14;
  localparam int unsigned TOTAL_W = 37;
  localparam int unsigned WIDE_W  = TOTAL_W + 1;   // total before wrap to field width
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CURR_W  = 16;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned GAIN_W  = 32;

  // Stream widths (whole bytes)
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 232;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (2 * DELTA_W + TURN_BITS + TOTAL_W
                                        + 2 * ANGLE_W + SPEED_W + CURR_W + TEMP_W + FRAME_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN    = 1'b1;

  // Unwrap stage result
  typedef struct packed {
    logic signed [DELTA_W-1:0]   delta;
    logic signed [TURN_BITS-1:0] turns;
    logic signed [WIDE_W-1:0]    total;
    logic signed [DELTA_W-1:0]   rel;
    logic signed [SPEED_W-1:0]   speed;
    logic signed [CURR_W-1:0]    current;
    logic        [TEMP_W-1:0]    temp;
    logic        [FRAME_W-1:0]   frames;
  } mfpt_mid_t;

  // Result item, laid out as m_axis_tdata (last field in the low bits)
  typedef struct packed {
    logic        [OUT_PAD_W-1:0] pad;
    logic        [FRAME_W-1:0]   frame_count;
    logic        [TEMP_W-1:0]    temperature_out;
    logic signed [CURR_W-1:0]    current_out;
    logic signed [SPEED_W-1:0]   speed_out;
    logic signed [ANGLE_W-1:0]   rel_angle;
    logic signed [DELTA_W-1:0]   relative_counts;
    logic signed [ANGLE_W-1:0]   tot_angle;
    logic signed [TOTAL_W-1:0]   total_counts;
    logic signed [TURN_BITS-1:0] turn_count;
    logic signed [DELTA_W-1:0]   delta_counts;
  } mfpt_res_t;

endpackage

`default_nettype wire

FILE: sv/mfpt_unwrap.sv
// ----------------------------------------------------------------------------
// Multi-turn unwrap stage
// Wraps the position delta, keeps the saturating turn counter and the frame
// counter, and forms the multi-turn total and the folded relative count.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpt_unwrap (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                load_i,
  input  wire  [mfpt_pkg::ENC_BITS-1:0]      position_i,
  input  wire  signed [mfpt_pkg::SPEED_W-1:0] speed_i,
  input  wire  signed [mfpt_pkg::CURR_W-1:0]  current_i,
  input  wire  [mfpt_pkg::TEMP_W-1:0]        temperature_i,
  input  wire  [mfpt_pkg::ENC_BITS-1:0]      center_offset_i,
  output mfpt_pkg::mfpt_mid_t                mid_o
);
  import mfpt_pkg::*;

  localparam logic signed [DELTA_W-1:0]   HALF_S  = DELTA_W'(ENC_HALF);
  localparam logic signed [DELTA_W:0]     RANGE_S = (DELTA_W + 1)'(ENC_COUNTS);
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  logic [ENC_BITS-1:0]         prev_q;
  logic signed [TURN_BITS-1:0] turns_q, turns_d;
  logic [FRAME_W-1:0]          frames_q, frames_d;
  mfpt_mid_t                   mid_q, mid_d;

  logic signed [DELTA_W-1:0] diff, delta_w;
  logic signed [DELTA_W:0]   pos_s, off_s, rel_w;
  logic signed [WIDE_W-1:0]  turn_base;

  // Delta wrap and turn counting
  always_comb begin
    diff    = $signed({1'b0, position_i}) - $signed({1'b0, prev_q});
    turns_d = turns_q;
    delta_w = diff;
    if (diff > HALF_S) begin
      if (turns_q != TURN_MIN) turns_d = turns_q - TURN_BITS'(1);
      delta_w = diff - DELTA_W'(RANGE_S);
    end else if (diff < -HALF_S) begin
      if (turns_q != TURN_MAX) turns_d = turns_q + TURN_BITS'(1);
      delta_w = diff + DELTA_W'(RANGE_S);
    end
    frames_d = frames_q + FRAME_W'(1);
  end

  // Multi-turn total and folded relative count
  always_comb begin
    pos_s     = $signed({2'b00, position_i});
    off_s     = $signed({2'b00, center_offset_i});
    turn_base = $signed({turns_d[TURN_BITS-1], turns_d, {ENC_BITS{1'b0}}});
    if ({1'b0, center_offset_i} >= (ENC_BITS + 1)'(ENC_HALF)) begin
      if ({1'b0, position_i} > ({1'b0, center_offset_i} - (ENC_BITS + 1)'(ENC_HALF)))
        rel_w = pos_s - off_s;
      else
        rel_w = pos_s + RANGE_S - off_s;
    end else begin
      if ({1'b0, position_i} > ({1'b0, center_offset_i} + (ENC_BITS + 1)'(ENC_HALF)))
        rel_w = pos_s - RANGE_S - off_s;
      else
        rel_w = pos_s - off_s;
    end
    mid_d.delta   = delta_w;
    mid_d.turns   = turns_d;
    mid_d.total   = turn_base + WIDE_W'(pos_s) - WIDE_W'(off_s);
    mid_d.rel     = rel_w[DELTA_W-1:0];
    mid_d.speed   = speed_i;
    mid_d.current = current_i;
    mid_d.temp    = temperature_i;
    mid_d.frames  = frames_d;
  end

  // Tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      turns_q  <= '0;
      frames_q <= '0;
    end else if (load_i) begin
      prev_q   <= position_i;
      turns_q  <= turns_d;
      frames_q <= frames_d;
    end
  end

  // Stage register
  always_ff @(posedge clk_i) begin
    if (load_i) mid_q <= mid_d;
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

FILE: sv/mfpt_scale.sv
// ----------------------------------------------------------------------------
// Angle scaling stage
// Turns the multi-turn total into Q8 degrees (times 45 over 4, truncated
// toward zero) and scales the relative count by the Q16 gain, both saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpt_scale (
  input  wire                                 clk_i,
  input  wire                                 load_i,
  input  mfpt_pkg::mfpt_mid_t                 mid_i,
  input  wire  signed [mfpt_pkg::GAIN_W-1:0]  angle_gain_i,
  output mfpt_pkg::mfpt_res_t                 res_o
);
  import mfpt_pkg::*;

  localparam int unsigned P45_W  = WIDE_W + 6;
  localparam int unsigned PROD_W = GAIN_W + DELTA_W;
  localparam logic signed [ANGLE_W-1:0] A_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] A_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  logic signed [P45_W-1:0]  t_ext, p45, p_bias, q45;
  logic signed [PROD_W-1:0] prod;
  logic signed [ANGLE_W-1:0] tangle, rangle;
  mfpt_res_t                res_q, res_d;

  // Total angle: x*45 by shift-add, divide by 4 toward zero, saturate
  always_comb begin
    t_ext  = P45_W'(mid_i.total);
    p45    = (t_ext <<< 5) + (t_ext <<< 3) + (t_ext <<< 2) + t_ext;
    p_bias = p45 + (p45[P45_W-1] ? P45_W'(3) : P45_W'(0));
    q45    = p_bias >>> 2;
    if (q45[P45_W-1:ANGLE_W-1] == '0 || q45[P45_W-1:ANGLE_W-1] == '1)
      tangle = q45[ANGLE_W-1:0];
    else
      tangle = q45[P45_W-1] ? A_MIN : A_MAX;
  end

  // Relative angle: gain times folded count, saturate
  always_comb begin
    prod = PROD_W'(angle_gain_i) * PROD_W'(mid_i.rel);
    if (prod[PROD_W-1:ANGLE_W-1] == '0 || prod[PROD_W-1:ANGLE_W-1] == '1)
      rangle = prod[ANGLE_W-1:0];
    else
      rangle = prod[PROD_W-1] ? A_MIN : A_MAX;
  end

  // Result assembly
  always_comb begin
    res_d.pad             = '0;
    res_d.frame_count     = mid_i.frames;
    res_d.temperature_out = mid_i.temp;
    res_d.current_out     = mid_i.current;
    res_d.speed_out       = mid_i.speed;
    res_d.rel_angle       = rangle;
    res_d.relative_counts = mid_i.rel;
    res_d.tot_angle       = tangle;
    res_d.total_counts    = mid_i.total[TOTAL_W-1:0];
    res_d.turn_count      = mid_i.turns;
    res_d.delta_counts    = mid_i.delta;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: sv/motor_feedback_position_tracker_unit.sv
// ----------------------------------------------------------------------------
// Motor feedback position tracker
// Multi-turn encoder unwrap with angle scaling over streaming channels.
// ----------------------------------------------------------------------------
// An accepted frame is held in the unwrap register, then in the result register,
// from which it is offered on the output stream.
// Throughput: one frame per cycle; when the output is not taken the result
// register holds and the unwrap register fills behind it, and a frame is
// accepted whenever the unwrap register is empty or moves on in that cycle.
// Reset: asynchronous, clears the turn, frame and previous-position state,
// both config registers and the stage valids.
`default_nettype none

module motor_feedback_position_tracker_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Configuration
  input  wire                                   cfg_we_i,
  input  wire  [mfpt_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [mfpt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Feedback frames
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // position[12:0], speed[28:13], current[44:29], temperature[52:45], zero pad
  input  wire  [mfpt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // Results
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // delta_counts[13:0], turn_count[37:14], total_counts[74:38],
  // tot_angle[106:75], relative_counts[120:107], rel_angle[152:121],
  // speed_out[168:153], current_out[184:169], temperature_out[192:185],
  // frame_count[224:193], zero pad
  output logic [mfpt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import mfpt_pkg::*;

  logic [ENC_BITS-1:0]      center_offset_q;
  logic signed [GAIN_W-1:0] angle_gain_q;
  logic                     v1_q, v1_d, v2_q, v2_d;
  logic                     in_acc, adv;
  mfpt_mid_t                mid;
  mfpt_res_t                res;

  // Pipeline flow control
  assign adv           = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = !v1_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    v1_d = v1_q;
    if (in_acc)   v1_d = 1'b1;
    else if (adv) v1_d = 1'b0;
    v2_d = v2_q;
    if (adv)                v2_d = 1'b1;
    else if (m_axis_tready) v2_d = 1'b0;
  end

  // Valids and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      center_offset_q <= '0;
      angle_gain_q    <= '0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CENTER_OFFSET: center_offset_q <= cfg_data_i[ENC_BITS-1:0];
          CFG_ANGLE_GAIN:    angle_gain_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  mfpt_unwrap u_unwrap (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_acc),
    .position_i      (s_axis_tdata[12:0]),
    .speed_i         ($signed(s_axis_tdata[28:13])),
    .current_i       ($signed(s_axis_tdata[44:29])),
    .temperature_i   (s_axis_tdata[52:45]),
    .center_offset_i (center_offset_q),
    .mid_o           (mid)
  );

  mfpt_scale u_scale (
    .clk_i        (clk_i),
    .load_i       (adv),
    .mid_i        (mid),
    .angle_gain_i (angle_gain_q),
    .res_o        (res)
  );

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = res;

endmodule

`default_nettype wire

FILE: sv/mfpt_checker.sv
// ----------------------------------------------------------------------------
// Motor feedback position tracker checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpt_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [mfpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import mfpt_pkg::*;

  logic out_acc;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Back-to-back results carry consecutive frame counts
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |-> m_axis_tdata[224:193] == $past(m_axis_tdata[224:193]) + 32'd1)
    else $error("frame count skipped or repeated");

  // Wrapped delta stays within half a turn
  a_delta_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[13:0]) >= -14'sd4096 &&
                       $signed(m_axis_tdata[13:0]) <= 14'sd4096))
    else $error("delta outside half-turn window");

  // Total and relative counts agree modulo one turn
  a_total_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[50:38] == m_axis_tdata[119:107])
    else $error("total and relative counts disagree within a turn");

endmodule

bind motor_feedback_position_tracker_unit mfpt_checker u_mfpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Motor feedback position tracker testbench
// Streams feedback frames through the tracker under several register settings
// and handshake modes, predicts every report in step with the input stream,
// and compares each report field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfpt_pkg::*;

  localparam longint COUNTS   = ENC_COUNTS;
  localparam longint HALF     = ENC_HALF;
  localparam longint TURN_MAX = (longint'(1) <<< (TURN_BITS - 1)) - 1;
  localparam longint TURN_MIN = -(longint'(1) <<< (TURN_BITS - 1));
  localparam longint ANG_MAX  = 64'sd2147483647;
  localparam longint ANG_MIN  = -64'sd2147483648;
  localparam int     LIMIT    = 1000000;
  localparam int     LATENCY  = 2;

  // DUT connections, all inputs known from time zero
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;

  motor_feedback_position_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker state and register copies
  logic        [ENC_BITS-1:0]  trk_prev   = '0;
  logic signed [TURN_BITS-1:0] trk_turns  = '0;
  logic        [FRAME_W-1:0]   trk_frames = '0;
  logic        [ENC_BITS-1:0]  cfg_offset = '0;
  logic signed [GAIN_W-1:0]    cfg_gain   = '0;
  longint                      turns_hi   = 0;
  longint                      turns_lo   = 0;

  // Stimulus and scoreboard bookkeeping
  logic [IN_TDATA_W-1:0] feedback_frames[$];
  mfpt_res_t             position_reports[$];
  logic [ENC_BITS-1:0]   gen_pos       = '0;
  int                    frames_queued = 0;
  int                    frames_taken  = 0;
  int                    results_seen  = 0;
  int                    reg_writes    = 0;
  int                    errors        = 0;
  int                    cycle_cnt     = 0;
  int                    src_idle_pct  = 0;
  int                    sink_stall_pct = 0;
  logic                  fb_taken      = 1'b0;
  mfpt_res_t             want, got;

  function automatic longint sat_angle(input longint v);
    if (v > ANG_MAX) return ANG_MAX;
    if (v < ANG_MIN) return ANG_MIN;
    return v;
  endfunction

  // Unwrap one frame, advance the tracker state and form its report
  function automatic mfpt_res_t track_frame(input logic [IN_TDATA_W-1:0] frame);
    mfpt_res_t rpt;
    longint    pos, prev, off, d, t, delta, total, rel;
    rpt  = '0;
    pos  = longint'(frame[ENC_BITS-1:0]);
    prev = longint'(trk_prev);
    off  = longint'(cfg_offset);   // 13-bit counts never need clamping at this size
    t    = longint'(trk_turns);
    trk_frames = trk_frames + FRAME_W'(1);
    d = pos - prev;
    if (d > HALF) begin
      if (t > TURN_MIN) t = t - 1;
      delta = d - COUNTS;
    end else if (d < -HALF) begin
      if (t < TURN_MAX) t = t + 1;
      delta = d + COUNTS;
    end else begin
      delta = d;
    end
    trk_prev  = frame[ENC_BITS-1:0];
    trk_turns = t[TURN_BITS-1:0];
    if (t > turns_hi) turns_hi = t;
    if (t < turns_lo) turns_lo = t;
    total = t * COUNTS + pos - off;
    // fold position around the offset into a half-turn window
    if (off >= HALF) begin
      rel = (pos > off - HALF) ? pos - off : pos + COUNTS - off;
    end else begin
      rel = (pos > off + HALF) ? pos - COUNTS - off : pos - off;
    end
    rpt.delta_counts    = delta[DELTA_W-1:0];
    rpt.turn_count      = t[TURN_BITS-1:0];
    rpt.total_counts    = total[TOTAL_W-1:0];
    rpt.tot_angle       = ANGLE_W'(sat_angle((total * 45) / 4));
    rpt.relative_counts = rel[DELTA_W-1:0];
    rpt.rel_angle       = ANGLE_W'(sat_angle(longint'(cfg_gain) * rel));
    rpt.speed_out       = frame[ENC_BITS +: SPEED_W];
    rpt.current_out     = frame[ENC_BITS + SPEED_W +: CURR_W];
    rpt.temperature_out = frame[ENC_BITS + SPEED_W + CURR_W +: TEMP_W];
    rpt.frame_count     = trk_frames;
    return rpt;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors <= 100) begin
        $display("%0t: %s expected %0h actual %0h", $time, fname, want_v, got_v);
      end
    end
  endtask

  // Request driver: new frames and sink ready change on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || fb_taken) begin
        if (feedback_frames.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= feedback_frames.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: check reports leaving, predict for requests entering
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > LIMIT) begin
        $display("Timeout after %0d cycles, %0d reports outstanding",
                 cycle_cnt, position_reports.size());
        $display("FAILED: results differ");
        $finish;
      end else begin
        if (m_axis_tvalid && m_axis_tready) begin
          got = m_axis_tdata;
          results_seen++;
          if (position_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report %h", $time, m_axis_tdata);
          end else begin
            want = position_reports.pop_front();
            check_field("delta_counts", want.delta_counts, got.delta_counts);
            check_field("turn_count", want.turn_count, got.turn_count);
            check_field("total_counts", want.total_counts, got.total_counts);
            check_field("tot_angle", want.tot_angle, got.tot_angle);
            check_field("relative_counts", want.relative_counts, got.relative_counts);
            check_field("rel_angle", want.rel_angle, got.rel_angle);
            check_field("speed_out", want.speed_out, got.speed_out);
            check_field("current_out", want.current_out, got.current_out);
            check_field("temperature_out", want.temperature_out, got.temperature_out);
            check_field("frame_count", want.frame_count, got.frame_count);
          end
        end
        fb_taken = s_axis_tvalid && s_axis_tready;
        if (fb_taken) begin
          position_reports.push_back(track_frame(s_axis_tdata));
          frames_taken++;
        end
      end
    end
  end

  task automatic queue_frame(input logic [ENC_BITS-1:0] pos, input logic [SPEED_W-1:0] spd,
                             input logic [CURR_W-1:0] cur, input logic [TEMP_W-1:0] tmp);
    feedback_frames.push_back(IN_TDATA_W'({tmp, cur, spd, pos}));
    gen_pos = pos;
    frames_queued++;
  endtask

  // Register write; the block is idle, so the copy is updated right away
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_OFFSET: cfg_offset = data[ENC_BITS-1:0];
      CFG_ANGLE_GAIN:    cfg_gain   = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Wait until every request is in and every report is out
  task automatic drain();
    while (frames_taken != frames_queued || position_reports.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Offset with junk in the unused high bits; gain at extremes or random
  task automatic pick_config();
    logic [CFG_DATA_W-1:0] off_w, gain_w, r;
    off_w = $urandom;
    r     = $urandom;
    case ($urandom_range(4))
      0: off_w[ENC_BITS-1:0] = '0;
      1: off_w[ENC_BITS-1:0] = '1;
      2: off_w[ENC_BITS-1:0] = ENC_BITS'(ENC_HALF);
      3: off_w[ENC_BITS-1:0] = ENC_BITS'(ENC_HALF - 1);
      default: ;
    endcase
    case ($urandom_range(5))
      0: gain_w = '0;
      1: gain_w = 32'h7fff_ffff;
      2: gain_w = 32'h8000_0000;
      3: gain_w = {{12{r[19]}}, r[19:0]};
      default: gain_w = r;
    endcase
    write_reg(CFG_CENTER_OFFSET, off_w);
    write_reg(CFG_ANGLE_GAIN, gain_w);
  endtask

  // Mostly plausible motion: small steps and steps right at the wrap threshold
  task automatic queue_random(input int n);
    int                  k;
    logic [ENC_BITS-1:0] p, step;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2: p = ENC_BITS'($urandom);
        3, 4, 5, 6: begin
          step = ENC_BITS'($urandom_range(64));
          p = $urandom_range(1) ? gen_pos + step : gen_pos - step;
        end
        default: begin
          step = ENC_BITS'($urandom_range(ENC_HALF + 2, ENC_HALF - 2));
          p = $urandom_range(1) ? gen_pos + step : gen_pos - step;
        end
      endcase
      queue_frame(p, SPEED_W'($urandom), CURR_W'($urandom), TEMP_W'($urandom));
    end
  endtask

  // Steady rotation, just under half a turn per frame, for a number of laps
  task automatic spin(input int laps, input bit up);
    int                  done;
    logic [ENC_BITS-1:0] p, step;
    done = 0;
    while (done < laps) begin
      step = ENC_BITS'($urandom_range(ENC_HALF - 1, ENC_HALF - 300));
      if (up) begin
        p = gen_pos + step;
        if (p < gen_pos) done++;
      end else begin
        p = gen_pos - step;
        if (p > gen_pos) done++;
      end
      queue_frame(p, SPEED_W'($urandom), CURR_W'($urandom), TEMP_W'($urandom));
    end
  endtask

  initial begin
    int src_modes[4];
    int sink_modes[4];
    int ph;
    src_modes  = '{0, 86, 0, 35};
    sink_modes = '{0, 0, 86, 35};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // First frame against zero, both wrap directions, exact half-turn steps
    queue_frame(13'd8191, 16'h7fff, 16'h8000, 8'hff);
    queue_frame(13'd4095, 16'h8000, 16'h7fff, 8'h00);
    queue_frame(13'd8191, 16'h0000, 16'hffff, 8'h80);
    queue_frame(13'd4094, 16'hffff, 16'h0000, 8'h01);
    queue_frame(13'd0,    16'h0001, 16'h8001, 8'h7f);
    queue_frame(13'd4097, 16'h1234, 16'h5678, 8'h55);
    queue_frame(13'd0,    16'hedcb, 16'ha987, 8'haa);
    queue_frame(13'd0,    16'h0000, 16'h0000, 8'h00);
    drain();

    // Fold edges at each offset extreme, gains at both limits
    write_reg(CFG_CENTER_OFFSET, 32'd4096);
    write_reg(CFG_ANGLE_GAIN, 32'h7fff_ffff);
    queue_frame(13'd0,    16'h7fff, 16'h7fff, 8'hff);
    queue_frame(13'd1,    16'h8000, 16'h8000, 8'h00);
    queue_frame(13'd4096, 16'h0000, 16'h0000, 8'h10);
    drain();
    write_reg(CFG_CENTER_OFFSET, 32'd8191);
    write_reg(CFG_ANGLE_GAIN, 32'h8000_0000);
    queue_frame(13'd4095, 16'h7fff, 16'h8000, 8'hfe);
    queue_frame(13'd4096, 16'h8000, 16'h7fff, 8'h02);
    queue_frame(13'd8191, 16'h0100, 16'hff00, 8'h20);
    drain();
    write_reg(CFG_CENTER_OFFSET, 32'hffff_e000 | 32'd4095);
    write_reg(CFG_ANGLE_GAIN, 32'h0001_0000);
    queue_frame(13'd8191, 16'h0042, 16'hffbe, 8'h40);
    queue_frame(13'd0,    16'hffbe, 16'h0042, 8'h41);
    queue_frame(13'd4095, 16'h0000, 16'h0000, 8'h42);
    drain();
    write_reg(CFG_CENTER_OFFSET, 32'd0);
    write_reg(CFG_ANGLE_GAIN, 32'hffff_0000);
    queue_frame(13'd4096, 16'h7ffe, 16'h8001, 8'hfd);
    queue_frame(13'd4097, 16'h8001, 16'h7ffe, 8'h03);
    queue_frame(13'd8191, 16'h0003, 16'hfffd, 8'hc0);
    queue_frame(13'd0,    16'hfffd, 16'h0003, 8'h0c);
    drain();

    // Random motion in each handshake mode; the mid-phase drain holds the sender
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_modes[ph];
      sink_stall_pct = sink_modes[ph];
      pick_config();
      queue_random(130);
      drain();
      pick_config();
      queue_random(130);
      drain();
    end

    // Spin up for some turns, then back down past zero into negative turns
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    pick_config();
    spin(20, 1'b1);
    drain();
    src_idle_pct   = 35;
    sink_stall_pct = 35;
    queue_random(40);
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    pick_config();
    spin(40, 1'b0);
    drain();
    src_idle_pct   = 35;
    sink_stall_pct = 35;
    queue_random(40);
    drain();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Run covered %0d frames and %0d reports over %0d register writes in four modes",
             frames_taken, results_seen, reg_writes);
    $display("Turn count spanned %0d to %0d across both spin directions",
             turns_lo, turns_hi);
    if (errors == 0 && position_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mfpt_pkg.sv
sv/mfpt_unwrap.sv
sv/mfpt_scale.sv
sv/motor_feedback_position_tracker_unit.sv
sv/mfpt_checker.sv
dv/tb.sv
